/* rtl/ntsg_pkg.sv */
// Shared types, codes and tables for the note tone sine generator.
package ntsg_pkg;

   localparam int SAMPLE_RATE    = 8000;
   localparam int QUARTER        = SAMPLE_RATE / 4;
   localparam int MAX_WHOLE_NOTE = 32000;
   localparam int WHOLE_RESET    = 32000;

   localparam int PHASE_W  = 13;
   localparam int STEP_W   = 12;
   localparam int LEN_W    = 15;
   localparam int SAMPLE_W = 15;
   localparam int QADDR_W  = 11;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [0:0] CMD_LOAD = 1'b0;
   localparam logic [0:0] CMD_TICK = 1'b1;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_LETTER = 2'd1;
   localparam logic [1:0] ERR_OCTAVE = 2'd2;
   localparam logic [1:0] ERR_LENGTH = 2'd3;

   localparam logic [0:0] REG_WHOLE_NOTE = 1'b0;

   // decoded note load
   typedef struct packed {
      logic [1:0]        err;
      logic [STEP_W-1:0] step;
      logic [LEN_W-1:0]  length;
   } load_type;

   // tone step in Hz, octave-major, semitone C..B
   localparam logic [STEP_W-1:0] TONE_TABLE [0:95] = '{
      12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
      12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
      12'd33,   12'd35,   12'd37,   12'd39,   12'd41,   12'd44,
      12'd46,   12'd49,   12'd52,   12'd55,   12'd58,   12'd62,
      12'd65,   12'd69,   12'd73,   12'd78,   12'd82,   12'd87,
      12'd92,   12'd98,   12'd104,  12'd110,  12'd117,  12'd123,
      12'd131,  12'd139,  12'd147,  12'd156,  12'd165,  12'd175,
      12'd185,  12'd196,  12'd208,  12'd220,  12'd233,  12'd247,
      12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
      12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
      12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
      12'd740,  12'd784,  12'd831,  12'd880,  12'd932,  12'd988,
      12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
      12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
      12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
      12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
   };

endpackage

/* rtl/ntsg_decode.sv */
// Note load decoder: letter, octave and length characters to tone step and length.
module ntsg_decode (
   input  logic [7:0]                      note_letter,
   input  logic [7:0]                      octave_char,
   input  logic [7:0]                      length_char,
   input  logic [ntsg_pkg::LEN_W-1:0]      whole_note,
   input  logic [ntsg_pkg::LEN_W-1:0]      held_length,
   output ntsg_pkg::load_type              load
);

   logic [7:0]  upper;
   logic [3:0]  semi;
   logic        semi_ok;
   logic        is_rest;
   logic        oct_ok;
   logic        len_ok;
   logic [ntsg_pkg::LEN_W-1:0] new_len;
   logic [ntsg_pkg::LEN_W+1:0] three_w;
   logic [6:0]  tone_idx;

   always_comb begin
      upper = (note_letter >= "a" && note_letter <= "z") ? note_letter - 8'd32 : note_letter;
      semi_ok = 1'b1;
      is_rest = 1'b0;
      semi    = 4'd0;
      unique case (upper)
         "C": semi = 4'd0;
         "X": semi = 4'd1;
         "D": semi = 4'd2;
         "Y": semi = 4'd3;
         "E": semi = 4'd4;
         "F": semi = 4'd5;
         "Z": semi = 4'd6;
         "G": semi = 4'd7;
         "V": semi = 4'd8;
         "A": semi = 4'd9;
         "W": semi = 4'd10;
         "B": semi = 4'd11;
         "P": is_rest = 1'b1;
         default: semi_ok = 1'b0;
      endcase
   end

   assign three_w = {2'b00, whole_note} + {1'b0, whole_note, 1'b0};

   always_comb begin
      len_ok  = 1'b1;
      new_len = held_length;
      unique case (length_char)
         "1": new_len = whole_note;
         "2": new_len = three_w[ntsg_pkg::LEN_W+1:2];
         "3": new_len = whole_note >> 1;
         "4": new_len = whole_note >> 2;
         "5": new_len = whole_note >> 3;
         "6": new_len = whole_note >> 4;
         "7": new_len = whole_note >> 5;
         " ": new_len = held_length;
         default: len_ok = 1'b0;
      endcase
   end

   assign oct_ok   = octave_char >= "0" && octave_char <= "7";
   assign tone_idx = {1'b0, octave_char[2:0], 3'b000} + {2'b00, octave_char[2:0], 2'b00}
                     + {3'b000, semi};

   always_comb begin
      // length fault wins, then letter, then octave
      priority if (!len_ok)              load.err = ntsg_pkg::ERR_LENGTH;
      else if (!semi_ok)                 load.err = ntsg_pkg::ERR_LETTER;
      else if (!is_rest && !oct_ok)      load.err = ntsg_pkg::ERR_OCTAVE;
      else                               load.err = ntsg_pkg::ERR_NONE;
      load.step   = is_rest ? '0 : ntsg_pkg::TONE_TABLE[tone_idx];
      load.length = new_len;
   end

endmodule

/* rtl/ntsg_sine_rom.sv */
// Quarter-wave sine ROM with registered read.
module ntsg_sine_rom (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [ntsg_pkg::QADDR_W-1:0]      rd_addr,
   output logic [ntsg_pkg::SAMPLE_W-1:0]     rd_data
);

   typedef logic [ntsg_pkg::SAMPLE_W-1:0] qwave_type [0:ntsg_pkg::QUARTER];

   localparam real PI_VALUE   = 3.14159265358979323846;
   localparam real UNIT_ANGLE = 2.0 * PI_VALUE / ntsg_pkg::SAMPLE_RATE;

   // trunc(16383.5 * sin(2*pi*m/SAMPLE_RATE)), all entries non-negative
   function automatic qwave_type build_qwave();
      qwave_type t;
      real       ang;
      for (int m = 0; m <= ntsg_pkg::QUARTER; m++) begin
         ang  = real'(m) * UNIT_ANGLE;
         t[m] = ntsg_pkg::SAMPLE_W'($rtoi(16383.5 * $sin(ang)));
      end
      return t;
   endfunction

   localparam qwave_type QWAVE = build_qwave();

   logic [ntsg_pkg::SAMPLE_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= QWAVE[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

/* rtl/note_tone_sine_generator_core.sv */
// Top level: note-driven sine tone generator with APB-style tempo register.
//
// Input channel (req_*): one transaction is a note load (command 0) or a
// sample tick (command 1). Output channel (rsp_*): exactly one result per
// input transaction, in order. A load returns its status in note_error with
// no sample; a tick while a note lasts returns a sine sample with
// sample_valid set and last_of_note on the final sample.
// rsp_valid rises in the cycle after acceptance; one transaction is
// accepted every cycle while no held result is stalled. The phase add,
// wrap and quarter-wave address are computed from the note state ahead
// of the sine ROM's registered read, which is also the result register.
// When the receiver stalls a held result, req_stall rises in the same
// cycle and the result stays unchanged until taken.
// Reset (synchronous, active high) clears the note state, empties the
// result register and sets whole_note_samples to 32000. The tempo register
// sits at byte address 0; writes whose low 15 bits exceed 32000 saturate.
module note_tone_sine_generator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [7:0]                          req_note_letter,
   input  logic [7:0]                          req_octave_char,
   input  logic [7:0]                          req_length_char,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ntsg_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                rsp_sample_valid,
   output logic                                rsp_last_of_note,
   output logic [1:0]                          rsp_note_error,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ntsg_pkg::ADDR_W-1:0]         paddr,
   input  logic [ntsg_pkg::DATA_W-1:0]         pwdata,
   output logic [ntsg_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int LW = ntsg_pkg::LEN_W;
   localparam int PW = ntsg_pkg::PHASE_W;
   localparam logic [0:0] REG_INDEX = ntsg_pkg::REG_WHOLE_NOTE;

   logic [LW-1:0] whole_ff, whole_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [ntsg_pkg::STEP_W-1:0] step_ff, step_in;
   logic [LW-1:0] left_ff, left_in;
   logic [LW-1:0] held_ff, held_in;

   logic       out_valid_ff, out_valid_in;
   logic       smp_valid_ff, smp_valid_in;
   logic       last_ff, last_in;
   logic [1:0] err_ff, err_in;
   logic       neg_ff, neg_in;

   logic advance;
   logic accept;
   logic is_tick;
   ntsg_pkg::load_type load;

   logic [PW-1:0] phase_cur;
   logic [PW:0]   phase_sum;
   logic [PW-1:0] phase_nxt;
   logic [PW-1:0] qaddr_wide;
   logic [ntsg_pkg::SAMPLE_W-1:0] rom_data;
   logic [LW-1:0] wdata_sat;
   logic          csr_write;

   // ---- configuration ----
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[ntsg_pkg::ADDR_W-1:2] == REG_INDEX);
   assign wdata_sat = (pwdata[LW-1:0] > LW'(ntsg_pkg::MAX_WHOLE_NOTE))
                      ? LW'(ntsg_pkg::MAX_WHOLE_NOTE) : pwdata[LW-1:0];
   assign whole_in  = csr_write ? wdata_sat : whole_ff;
   assign prdata    = (paddr[ntsg_pkg::ADDR_W-1:2] == REG_INDEX)
                      ? {{(ntsg_pkg::DATA_W-LW){1'b0}}, whole_ff} : '0;

   // ---- handshake ----
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   ntsg_decode u_decode (
      .note_letter (req_note_letter),
      .octave_char (req_octave_char),
      .length_char (req_length_char),
      .whole_note  (whole_ff),
      .held_length (held_ff),
      .load        (load)
   );

   // ---- phase accumulator, one wrap is enough as step < SAMPLE_RATE ----
   assign phase_cur = (phase_ff < PW'(ntsg_pkg::SAMPLE_RATE)) ? phase_ff : '0;
   assign phase_sum = {1'b0, phase_cur} + {{(PW+1-ntsg_pkg::STEP_W){1'b0}}, step_ff};
   assign phase_nxt = (phase_sum >= (PW+1)'(ntsg_pkg::SAMPLE_RATE))
                      ? PW'(phase_sum - (PW+1)'(ntsg_pkg::SAMPLE_RATE)) : phase_sum[PW-1:0];

   // quarter-wave folding
   always_comb begin
      priority if (phase_cur <= PW'(ntsg_pkg::QUARTER)) begin
         qaddr_wide = phase_cur;
         neg_in     = 1'b0;
      end else if (phase_cur <= PW'(2 * ntsg_pkg::QUARTER)) begin
         qaddr_wide = PW'(2 * ntsg_pkg::QUARTER) - phase_cur;
         neg_in     = 1'b0;
      end else if (phase_cur <= PW'(3 * ntsg_pkg::QUARTER)) begin
         qaddr_wide = phase_cur - PW'(2 * ntsg_pkg::QUARTER);
         neg_in     = 1'b1;
      end else begin
         qaddr_wide = PW'(4 * ntsg_pkg::QUARTER) - phase_cur;
         neg_in     = 1'b1;
      end
   end

   ntsg_sine_rom u_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (qaddr_wide[ntsg_pkg::QADDR_W-1:0]),
      .rd_data (rom_data)
   );

   // ---- note state ----
   assign is_tick = (req_command == ntsg_pkg::CMD_TICK);

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      left_in      = left_ff;
      held_in      = held_ff;
      smp_valid_in = 1'b0;
      last_in      = 1'b0;
      err_in       = ntsg_pkg::ERR_NONE;
      if (accept) begin
         if (!is_tick) begin
            err_in = load.err;
            if (load.err != ntsg_pkg::ERR_NONE) begin
               left_in = '0;
            end else begin
               step_in  = load.step;
               held_in  = load.length;
               left_in  = load.length;
               phase_in = '0;
            end
         end else if (left_ff != '0) begin
            smp_valid_in = 1'b1;
            last_in      = (left_ff == LW'(1));
            phase_in     = phase_nxt;
            left_in      = left_ff - LW'(1);
         end
      end
   end

   assign out_valid_in = advance ? req_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff     <= LW'(ntsg_pkg::WHOLE_RESET);
         phase_ff     <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         whole_ff     <= whole_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result flags, held while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         smp_valid_ff <= smp_valid_in;
         last_ff      <= last_in;
         err_ff       <= err_in;
         neg_ff       <= neg_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sample_valid = smp_valid_ff;
   assign rsp_last_of_note = last_ff;
   assign rsp_note_error   = err_ff;
   assign rsp_sample       = !smp_valid_ff ? '0 : (neg_ff ? -rom_data : rom_data);

endmodule

/* rtl/ntsg_checker.sv */
// Port-level checker for the note tone sine generator, bound to the top level.
module ntsg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [ntsg_pkg::SAMPLE_W-1:0] rsp_sample,
   input logic                                 rsp_sample_valid,
   input logic                                 rsp_last_of_note,
   input logic [1:0]                           rsp_note_error
);

   // a stalled transaction holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample)
                                 && $stable(rsp_note_error))
      else $error("stalled result changed");

   // every accepted transaction gives a result in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("result missing after accept");

   // a failed load never carries a sample
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_note_error != ntsg_pkg::ERR_NONE)
      |-> !rsp_sample_valid && (rsp_sample == '0) && !rsp_last_of_note)
      else $error("load status with sample");

   // last sample flag only on a real sample; idle ticks read zero
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sample_valid |-> !rsp_last_of_note && (rsp_sample == '0))
      else $error("last or sample without sample_valid");

endmodule

bind note_tone_sine_generator_core ntsg_checker u_ntsg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sample       (rsp_sample),
   .rsp_sample_valid (rsp_sample_valid),
   .rsp_last_of_note (rsp_last_of_note),
   .rsp_note_error   (rsp_note_error)
);

/* test/note_tone_sine_generator_core_checker.sv */
// Checker for the note tone sine generator: predicts each result and compares it.
module note_tone_sine_generator_core_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [7:0]                           req_note_letter,
   input  logic [7:0]                           req_octave_char,
   input  logic [7:0]                           req_length_char,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [ntsg_pkg::SAMPLE_W-1:0] rsp_sample,
   input  logic                                 rsp_sample_valid,
   input  logic                                 rsp_last_of_note,
   input  logic [1:0]                           rsp_note_error,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ntsg_pkg::ADDR_W-1:0]          paddr,
   input  logic [ntsg_pkg::DATA_W-1:0]          pwdata,
   input  logic [ntsg_pkg::DATA_W-1:0]          prdata,
   input  logic                                 pready,
   output int                                   failures,
   output int                                   in_flight
);

   localparam int unsigned RATE_HZ     = 8000;
   localparam int unsigned QTR         = RATE_HZ / 4;
   localparam int unsigned TEMPO_MAX   = 32000;
   localparam int unsigned TEMPO_RESET = 32000;
   localparam int          NO_SEMI     = -1;
   localparam int          REST_SEMI   = 12;
   localparam logic [7:0]  LEN_KEEP    = " ";
   localparam bit [63:0]   Q60_ONE     = 64'h1000_0000_0000_0000;
   localparam logic [ntsg_pkg::ADDR_W-1:0] TEMPO_ADDR =
      ntsg_pkg::ADDR_W'(4 * ntsg_pkg::REG_WHOLE_NOTE);

   typedef struct packed {
      logic signed [ntsg_pkg::SAMPLE_W-1:0] sample;
      logic                                 sample_valid;
      logic                                 last_of_note;
      logic [1:0]                           note_error;
   } tone_out_type;

   // tone step in Hz per octave and semitone
   localparam int unsigned STEP_HZ [0:7][0:11] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{33, 35, 37, 39, 41, 44, 46, 49, 52, 55, 58, 62},
      '{65, 69, 73, 78, 82, 87, 92, 98, 104, 110, 117, 123},
      '{131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247},
      '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494},
      '{523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988},
      '{1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976},
      '{2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951}
   };

   int          sine_quarter [0:QTR];
   int unsigned tempo;
   bit [ntsg_pkg::PHASE_W-1:0] phase;
   bit [ntsg_pkg::STEP_W-1:0]  step;
   bit [ntsg_pkg::LEN_W-1:0]   remaining;
   bit [ntsg_pkg::LEN_W-1:0]   note_len;
   tone_out_type owed_outputs [$];

   function automatic bit [63:0] mul_q(bit [63:0] a, bit [63:0] b, int sh);
      bit [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod >> sh;
      return prod[63:0];
   endfunction

   function automatic bit [63:0] arctan_recip(bit [63:0] n);
      bit [63:0] power, sum, term, k;
      bit        sub;
      power = Q60_ONE / n;
      sum   = power;
      k     = 1;
      sub   = 1'b1;
      while (power != 0) begin
         power = power / (n * n);
         term  = power / (2 * k + 1);
         sum   = sub ? sum - term : sum + term;
         sub   = !sub;
         k++;
      end
      return sum;
   endfunction

   // Taylor series in Q60, angle at most pi/4
   function automatic bit [63:0] series_q60(bit [63:0] theta, bit cosine);
      bit [63:0] sq, term, sum, k;
      bit        sub;
      sq   = mul_q(theta, theta, 60);
      term = cosine ? Q60_ONE : theta;
      sum  = term;
      k    = cosine ? 64'd0 : 64'd1;
      sub  = 1'b1;
      while (term != 0) begin
         term = mul_q(term, sq, 60) / ((k + 1) * (k + 2));
         sum  = sub ? sum - term : sum + term;
         sub  = !sub;
         k    = k + 2;
      end
      return sum;
   endfunction

   function automatic void build_sine_table();
      bit [63:0] pi_q, unit, s;
      pi_q = 16 * arctan_recip(64'd5) - 4 * arctan_recip(64'd239);
      unit = pi_q / (RATE_HZ / 2);
      for (int m = 0; m <= QTR; m++) begin
         if (2 * m <= QTR) s = series_q60(unit * m, 1'b0);
         else s = series_q60(unit * (QTR - m), 1'b1);
         // 16383.5 * s, truncated
         sine_quarter[m] = int'(mul_q(s, 64'd32767, 61));
      end
   endfunction

   function automatic logic signed [ntsg_pkg::SAMPLE_W-1:0] sine_at(int unsigned p);
      int v;
      if (p <= QTR) v = sine_quarter[p];
      else if (p <= 2 * QTR) v = sine_quarter[2 * QTR - p];
      else if (p <= 3 * QTR) v = -sine_quarter[p - 2 * QTR];
      else v = -sine_quarter[4 * QTR - p];
      return v[ntsg_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic int letter_semitone(logic [7:0] c);
      if (c >= "a" && c <= "z") c = c - 8'd32;
      case (c)
         "C": return 0;
         "X": return 1;
         "D": return 2;
         "Y": return 3;
         "E": return 4;
         "F": return 5;
         "Z": return 6;
         "G": return 7;
         "V": return 8;
         "A": return 9;
         "W": return 10;
         "B": return 11;
         "P": return REST_SEMI;
         default: return NO_SEMI;
      endcase
   endfunction

   function automatic tone_out_type advance_note(logic cmd, logic [7:0] letter,
                                                 logic [7:0] oct, logic [7:0] len);
      tone_out_type r;
      int           semi;
      int unsigned  new_len;
      int unsigned  p;
      r = '0;
      r.note_error = ntsg_pkg::ERR_NONE;
      if (cmd == ntsg_pkg::CMD_LOAD) begin
         new_len = note_len;
         semi    = letter_semitone(letter);
         if (len >= "1" && len <= "7") begin
            case (len)
               "1": new_len = tempo;
               "2": new_len = (tempo * 3) / 4;
               "3": new_len = tempo / 2;
               "4": new_len = tempo / 4;
               "5": new_len = tempo / 8;
               "6": new_len = tempo / 16;
               default: new_len = tempo / 32;
            endcase
         end else if (len != LEN_KEEP) begin
            r.note_error = ntsg_pkg::ERR_LENGTH;
         end
         if (r.note_error == ntsg_pkg::ERR_NONE && semi == NO_SEMI)
            r.note_error = ntsg_pkg::ERR_LETTER;
         if (r.note_error == ntsg_pkg::ERR_NONE && semi != REST_SEMI &&
             (oct < "0" || oct > "7"))
            r.note_error = ntsg_pkg::ERR_OCTAVE;
         if (r.note_error != ntsg_pkg::ERR_NONE) begin
            remaining = '0;
         end else begin
            step      = (semi == REST_SEMI) ? '0 : STEP_HZ[oct - "0"][semi];
            note_len  = new_len[ntsg_pkg::LEN_W-1:0];
            remaining = note_len;
            phase     = '0;
         end
      end else if (remaining != 0) begin
         p                = (phase < RATE_HZ) ? phase : 0;
         r.sample         = sine_at(p);
         r.sample_valid   = 1'b1;
         r.last_of_note   = (remaining == 1);
         p                = p + step;
         while (p >= RATE_HZ) p = p - RATE_HZ;
         phase            = p[ntsg_pkg::PHASE_W-1:0];
         remaining        = remaining - 1'b1;
      end
      return r;
   endfunction

   initial build_sine_table();

   always @(posedge clock) begin
      tone_out_type want;
      if (reset) begin
         tempo     = TEMPO_RESET;
         phase     = '0;
         step      = '0;
         remaining = '0;
         note_len  = '0;
         failures  = 0;
         owed_outputs.delete();
      end else begin
         // results first, so a result can never match an item taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (owed_outputs.size() == 0) begin
               $error("result transaction with nothing expected");
               failures++;
            end else begin
               want = owed_outputs.pop_front();
               if (rsp_sample !== want.sample) begin
                  $error("sample: expected %0d, actual %0d", want.sample, rsp_sample);
                  failures++;
               end
               if (rsp_sample_valid !== want.sample_valid) begin
                  $error("sample_valid: expected %0d, actual %0d",
                         want.sample_valid, rsp_sample_valid);
                  failures++;
               end
               if (rsp_last_of_note !== want.last_of_note) begin
                  $error("last_of_note: expected %0d, actual %0d",
                         want.last_of_note, rsp_last_of_note);
                  failures++;
               end
               if (rsp_note_error !== want.note_error) begin
                  $error("note_error: expected %0d, actual %0d",
                         want.note_error, rsp_note_error);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall)
            owed_outputs.push_back(advance_note(req_command, req_note_letter,
                                                req_octave_char, req_length_char));
         if (psel && penable && pready && paddr == TEMPO_ADDR) begin
            if (pwrite) begin
               tempo = pwdata[ntsg_pkg::LEN_W-1:0];
               if (tempo > TEMPO_MAX) tempo = TEMPO_MAX;
            end else if (prdata !== ntsg_pkg::DATA_W'(tempo)) begin
               $error("whole_note_samples: expected %0d, actual %0d", tempo, prdata);
               failures++;
            end
         end
      end
      in_flight = owed_outputs.size();
   end

endmodule

/* test/note_tone_sine_generator_core_test.sv */
// Testbench top: reset, note and tick stimulus, tempo writes and the verdict.
module note_tone_sine_generator_core_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [ntsg_pkg::ADDR_W-1:0] TEMPO_ADDR =
      ntsg_pkg::ADDR_W'(4 * ntsg_pkg::REG_WHOLE_NOTE);
   localparam logic [7:0] NOTE_CHARS [0:12] =
      '{"C", "X", "D", "Y", "E", "F", "Z", "G", "V", "A", "W", "B", "P"};

   logic                                 clock           = 1'b0;
   logic                                 reset           = 1'b1;
   logic                                 req_valid       = 1'b0;
   logic                                 req_stall;
   logic                                 req_command     = ntsg_pkg::CMD_TICK;
   logic [7:0]                           req_note_letter = 8'd0;
   logic [7:0]                           req_octave_char = 8'd0;
   logic [7:0]                           req_length_char = 8'd0;
   logic                                 rsp_valid;
   logic                                 rsp_stall       = 1'b0;
   logic signed [ntsg_pkg::SAMPLE_W-1:0] rsp_sample;
   logic                                 rsp_sample_valid;
   logic                                 rsp_last_of_note;
   logic [1:0]                           rsp_note_error;
   logic                                 psel            = 1'b0;
   logic                                 penable         = 1'b0;
   logic                                 pwrite          = 1'b0;
   logic [ntsg_pkg::ADDR_W-1:0]          paddr           = '0;
   logic [ntsg_pkg::DATA_W-1:0]          pwdata          = '0;
   logic [ntsg_pkg::DATA_W-1:0]          prdata;
   logic                                 pready;
   int                                   failures;
   int                                   in_flight;
   int                                   cycles;
   bit                                   idling          = 1'b1;
   int                                   stall_left      = 0;

   note_tone_sine_generator_core dut (.*);
   note_tone_sine_generator_core_checker u_checker (.*);

   always #2 clock = ~clock;

   // receiver back-pressure in short bursts
   always @(negedge clock) begin
      if (reset || !idling) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(logic cmd, logic [7:0] letter, logic [7:0] octave,
                            logic [7:0] length);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_note_letter <= letter;
      req_octave_char <= octave;
      req_length_char <= length;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic random_item();
      logic [7:0] letter, octave, length;
      int         pick;
      pick   = $urandom_range(0, 99);
      letter = NOTE_CHARS[$urandom_range(0, 12)] | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      octave = 8'("0" + $urandom_range(0, 7));
      length = ($urandom_range(0, 7) == 0) ? 8'(" ") : 8'("0" + $urandom_range(1, 7));
      if (pick < 84) begin
         send_item(ntsg_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
         if (pick >= 96) begin
            // broken load: some fields replaced by arbitrary bytes
            if ($urandom_range(0, 1)) letter = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) octave = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) length = 8'($urandom_range(0, 255));
         end
         send_item(ntsg_pkg::CMD_LOAD, letter, octave, length);
      end
   endtask

   task automatic run_random(int count);
      repeat (count) random_item();
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (in_flight != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_cycle(bit write, logic [ntsg_pkg::DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= TEMPO_ADDR;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_tempo(logic [ntsg_pkg::DATA_W-1:0] value);
      drain();
      csr_cycle(1'b1, value);
      @(negedge clock);
      csr_cycle(1'b0, '0);
      @(negedge clock);
   endtask

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset tempo
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);  // nothing playing
      send_item(ntsg_pkg::CMD_LOAD, "C", "4", " ");        // held length still zero
      send_item(ntsg_pkg::CMD_TICK, 8'hFF, 8'hFF, 8'hFF);
      send_item(ntsg_pkg::CMD_LOAD, "A", "4", "7");
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00);  // bad length wins
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);  // note was stopped
      send_item(ntsg_pkg::CMD_LOAD, "A", "4", " ");        // keeps previous length
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_LOAD, "q", "3", "4");
      send_item(ntsg_pkg::CMD_LOAD, "b", 8'hFF, "2");
      send_item(ntsg_pkg::CMD_LOAD, 8'hFF, 8'hFF, 8'hFF);
      send_item(ntsg_pkg::CMD_LOAD, 8'hFF, "0", "1");      // bad letter with a valid octave
      send_item(ntsg_pkg::CMD_LOAD, "p", 8'hFF, "3");      // rest ignores octave
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_LOAD, "B", "7", "1");        // largest step, phase wraps
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_LOAD, "C", "0", "6");
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
      send_item(ntsg_pkg::CMD_LOAD, "e", "8", "5");
      send_item(ntsg_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);

      run_random(180);
      write_tempo(32'd0);
      run_random(60);
      write_tempo(32'h0000_7FFF);                          // saturates
      run_random(150);
      write_tempo(32'd32);
      run_random(200);
      idling = 1'b0;
      write_tempo(32'd1);
      run_random(60);
      idling = 1'b1;
      write_tempo(32'hFFFE_0064);                          // upper bits dropped
      run_random(200);
      for (int i = 0; i < 3; i++) begin
         if (i == 2) idling = 1'b0;
         write_tempo(ntsg_pkg::DATA_W'($urandom_range(2, 400)));
         run_random(150);
      end

      drain();
      repeat (4) @(negedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
